// ===== rtl/mrtu_pkg.sv =====
// Shared types, constants and the CRC byte step of the Modbus RTU request framer.
package mrtu_pkg;

  localparam logic [7:0]  FuncRead      = 8'h03;
  localparam logic [7:0]  FuncWriteOne  = 8'h06;
  localparam logic [7:0]  FuncWriteMany = 8'h10;
  localparam logic [15:0] CrcInit       = 16'hFFFF;
  localparam logic [15:0] CrcPoly       = 16'hA001;

  localparam int unsigned CmdDepth = 4;
  localparam int unsigned OutDepth = 2;

  // Input item kinds
  localparam logic [1:0] KindRead  = 2'd0;
  localparam logic [1:0] KindStart = 2'd1;
  localparam logic [1:0] KindData  = 2'd2;

  typedef enum logic [1:0] {
    CmdRead = 2'd0,
    CmdHdr  = 2'd1,
    CmdData = 2'd2
  } cmd_kind_e;

  // One command from the front to the serialiser
  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  slave;
    logic [15:0] addr;
    logic [7:0]  count;
    logic [15:0] word;
    logic        close;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_t;

  // Fold one byte into the Modbus CRC-16
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/mrtu_fifo.sv =====
// Small register queue used between the framer stages.
module mrtu_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/mrtu_front.sv =====
// Front stage: accepts request items, tracks the open write and issues commands.
module mrtu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    kind_i,
  input  logic [7:0]    slave_address_i,
  input  logic [15:0]   register_address_i,
  input  logic [7:0]    register_count_i,
  input  logic [15:0]   data_word_i,
  output logic          cmd_push_o,
  output mrtu_pkg::cmd_t cmd_o,
  input  logic          cmd_full_i
);

  import mrtu_pkg::*;

  logic       open_q, open_d;
  logic [7:0] words_q, words_d;
  logic       take;

  assign full = cmd_full_i;
  assign take = push && !cmd_full_i;

  // Classify the item and update the write tracking
  always_comb begin
    open_d      = open_q;
    words_d     = words_q;
    cmd_push_o  = 1'b0;
    cmd_o.kind  = CmdRead;
    cmd_o.slave = slave_address_i;
    cmd_o.addr  = register_address_i;
    cmd_o.count = register_count_i;
    cmd_o.word  = data_word_i;
    cmd_o.close = 1'b1;
    if (take) begin
      case (kind_i)
        KindRead: begin
          cmd_push_o = 1'b1;
          open_d     = 1'b0;
          words_d    = '0;
        end
        KindStart: begin
          cmd_push_o  = 1'b1;
          cmd_o.kind  = CmdHdr;
          cmd_o.close = (register_count_i == 8'd0);
          open_d      = (register_count_i != 8'd0);
          words_d     = register_count_i;
        end
        KindData: begin
          // Drop data words with no write open
          if (open_q) begin
            cmd_push_o  = 1'b1;
            cmd_o.kind  = CmdData;
            cmd_o.close = (words_q == 8'd1);
            words_d     = words_q - 8'd1;
            if (words_q == 8'd1) begin
              open_d = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      words_q <= '0;
    end else begin
      open_q  <= open_d;
      words_q <= words_d;
    end
  end

endmodule

// ===== rtl/mrtu_back.sv =====
// Back stage: serialises commands into frame bytes and keeps the running CRC.
module mrtu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mrtu_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  output logic           out_push_o,
  output mrtu_pkg::out_t out_o,
  input  logic           out_full_i
);

  import mrtu_pkg::*;

  logic [3:0]  idx_q, idx_d;
  logic [15:0] crc_q, crc_d;
  logic [3:0]  body_len, total;
  logic [7:0]  body_byte;
  logic [15:0] crc_base;
  logic        step;

  assign step = !cmd_empty_i && !out_full_i;

  // Work out the frame body length of this command
  always_comb begin
    unique case (cmd_i.kind)
      CmdRead: body_len = 4'd6;
      CmdHdr:  body_len = (cmd_i.count == 8'd1) ? 4'd4 : 4'd7;
      CmdData: body_len = 4'd2;
      default: body_len = 4'd2;
    endcase
    total = body_len + (cmd_i.close ? 4'd2 : 4'd0);
  end

  // Select the body byte at the current index
  always_comb begin
    if (cmd_i.kind == CmdData) begin
      body_byte = idx_q[0] ? cmd_i.word[7:0] : cmd_i.word[15:8];
    end else begin
      case (idx_q[2:0])
        3'd0: body_byte = cmd_i.slave;
        3'd1: body_byte = (cmd_i.kind == CmdRead) ? FuncRead :
                          (cmd_i.count == 8'd1) ? FuncWriteOne : FuncWriteMany;
        3'd2: body_byte = cmd_i.addr[15:8];
        3'd3: body_byte = cmd_i.addr[7:0];
        3'd4: body_byte = 8'h00;
        3'd5: body_byte = cmd_i.count;
        3'd6: body_byte = {cmd_i.count[6:0], 1'b0};
        default: body_byte = 8'h00;
      endcase
    end
  end

  // A new frame restarts the CRC
  assign crc_base = (idx_q == 4'd0 && cmd_i.kind != CmdData) ? CrcInit : crc_q;

  // Emit one byte per transfer and advance through the command
  always_comb begin
    idx_d      = idx_q;
    crc_d      = crc_q;
    cmd_pop_o  = 1'b0;
    out_push_o = step;
    out_o.last = 1'b0;
    if (idx_q < body_len) begin
      out_o.data = body_byte;
    end else if (idx_q == body_len) begin
      out_o.data = crc_q[7:0];
    end else begin
      out_o.data = crc_q[15:8];
      out_o.last = 1'b1;
    end
    if (step) begin
      if (idx_q < body_len) begin
        crc_d = crc_byte(crc_base, body_byte);
      end else if (idx_q != body_len) begin
        crc_d = CrcInit;
      end
      if (idx_q == total - 4'd1) begin
        idx_d     = '0;
        cmd_pop_o = 1'b1;
      end else begin
        idx_d = idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      crc_q <= CrcInit;
    end else begin
      idx_q <= idx_d;
      crc_q <= crc_d;
    end
  end

endmodule

// ===== rtl/modbus_rtu_request_framer.sv =====
// Top level of the Modbus RTU request framer.
// Input queue side: present an item on kind_i and the field ports with push
// high; it transfers at a rising edge where full is low. Read items give an
// 8-byte read frame, write start items give the header, data words give two
// bytes each, and the last word (or a zero count start) closes the frame
// with the CRC-16, low byte first. Stray data words and kind 3 are dropped.
// Result queue side: while empty is low, frame_byte_o and frame_last_o hold
// the oldest byte; it transfers at a rising edge where pop is high.
// The first byte of an item goes from the command queue, written at the item's
// transfer, through the output queue before it reaches the result ports.
// Throughput: one frame byte per cycle while the output queue has room, set
// by the serialiser, which emits one byte per cycle; a data word thus gives
// 2 bytes (4 when it closes the frame), a read frame 8, a zero count write 9.
// A 4-entry command queue separates the front from the serialiser and a
// 2-entry output queue holds bytes while pop is low; full rises when the
// command queue fills. Reset empties both queues, closes any open write and
// sets the CRC to 0xFFFF.
module modbus_rtu_request_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  slave_address_i,
  input  logic [15:0] register_address_i,
  input  logic [7:0]  register_count_i,
  input  logic [15:0] data_word_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  frame_byte_o,
  output logic        frame_last_o
);

  import mrtu_pkg::*;

  cmd_t cmd_wr, cmd_rd;
  out_t out_wr, out_rd;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic out_push, out_full;

  mrtu_front u_front (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .kind_i,
    .slave_address_i,
    .register_address_i,
    .register_count_i,
    .data_word_i,
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_wr),
    .cmd_full_i (cmd_full)
  );

  mrtu_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (cmd_push),
    .data_i  (cmd_wr),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_rd),
    .empty_o (cmd_empty)
  );

  mrtu_back u_back (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd_rd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .out_push_o  (out_push),
    .out_o       (out_wr),
    .out_full_i  (out_full)
  );

  mrtu_fifo #(
    .Width ($bits(out_t)),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (out_push),
    .data_i  (out_wr),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_rd),
    .empty_o (empty)
  );

  assign frame_byte_o = out_rd.data;
  assign frame_last_o = out_rd.last;

endmodule

// ===== dv/modbus_rtu_request_framer_checker.sv =====
// Checker for the Modbus RTU request framer: frame byte predictor and comparison.
module modbus_rtu_request_framer_checker
  import mrtu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  slave_address_i,
  input  logic [15:0] register_address_i,
  input  logic [7:0]  register_count_i,
  input  logic [15:0] data_word_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  frame_byte_o,
  input  logic        frame_last_o,
  output int          error_count_o,
  output int          pending_bytes_o
);

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_octet_t;

  // Bytes owed by the framer, oldest first
  frame_octet_t owed_bytes[$];

  // Predicted framer state
  logic [15:0] frame_crc;
  logic [7:0]  words_left;
  logic        write_active;
  int          errors;

  // Fold one byte into the Modbus CRC-16, one bit at a time
  function automatic logic [15:0] crc16_fold(logic [15:0] crc, logic [7:0] octet);
    logic [15:0] acc;
    logic        lsb;
    acc = crc ^ {8'h00, octet};
    for (int i = 0; i < 8; i++) begin
      lsb = acc[0];
      acc = {1'b0, acc[15:1]};
      if (lsb) begin
        acc = acc ^ CrcPoly;
      end
    end
    return acc;
  endfunction

  // Queue a body byte and add it to the CRC
  task automatic owe_body(input logic [7:0] octet);
    frame_octet_t entry;
    entry.value = octet;
    entry.last  = 1'b0;
    owed_bytes.push_back(entry);
    frame_crc = crc16_fold(frame_crc, octet);
  endtask

  // Queue the CRC, low byte first, and close the frame
  task automatic owe_crc_tail();
    frame_octet_t entry;
    entry.value = frame_crc[7:0];
    entry.last  = 1'b0;
    owed_bytes.push_back(entry);
    entry.value = frame_crc[15:8];
    entry.last  = 1'b1;
    owed_bytes.push_back(entry);
    frame_crc    = CrcInit;
    words_left   = 8'd0;
    write_active = 1'b0;
  endtask

  // Work out the frame bytes one accepted item causes
  task automatic frame_request(input logic [1:0] kind, input logic [7:0] slave,
                               input logic [15:0] addr, input logic [7:0] count,
                               input logic [15:0] word);
    logic [7:0] byte_count;
    byte_count = count << 1;
    case (kind)
      KindRead: begin
        frame_crc    = CrcInit;
        words_left   = 8'd0;
        write_active = 1'b0;
        owe_body(slave);
        owe_body(FuncRead);
        owe_body(addr[15:8]);
        owe_body(addr[7:0]);
        owe_body(8'h00);
        owe_body(count);
        owe_crc_tail();
      end
      KindStart: begin
        // a start abandons any open write
        frame_crc = CrcInit;
        owe_body(slave);
        owe_body((count == 8'd1) ? FuncWriteOne : FuncWriteMany);
        owe_body(addr[15:8]);
        owe_body(addr[7:0]);
        if (count != 8'd1) begin
          owe_body(8'h00);
          owe_body(count);
          owe_body(byte_count);
        end
        if (count == 8'd0) begin
          owe_crc_tail();
        end else begin
          words_left   = count;
          write_active = 1'b1;
        end
      end
      KindData: begin
        // drop stray words
        if (write_active) begin
          owe_body(word[15:8]);
          owe_body(word[7:0]);
          words_left = words_left - 8'd1;
          if (words_left == 8'd0) begin
            owe_crc_tail();
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // Compare each result transfer, then predict each input transfer
  always @(posedge clk_i or negedge rst_ni) begin
    frame_octet_t head;
    if (!rst_ni) begin
      owed_bytes.delete();
      frame_crc       = CrcInit;
      words_left      = 8'd0;
      write_active    = 1'b0;
      errors          = 0;
      error_count_o   <= 0;
      pending_bytes_o <= 0;
    end else begin
      if (pop && !empty) begin
        if (owed_bytes.size() == 0) begin
          errors++;
          $display("%0t: unexpected frame byte, expected none, got %h last %b",
                   $time, frame_byte_o, frame_last_o);
        end else begin
          head = owed_bytes.pop_front();
          if (frame_byte_o !== head.value) begin
            errors++;
            $display("%0t: frame_byte mismatch, expected %h, got %h",
                     $time, head.value, frame_byte_o);
          end
          if (frame_last_o !== head.last) begin
            errors++;
            $display("%0t: frame_last mismatch, expected %b, got %b",
                     $time, head.last, frame_last_o);
          end
        end
      end
      if (push && !full) begin
        frame_request(kind_i, slave_address_i, register_address_i,
                      register_count_i, data_word_i);
      end
      error_count_o   <= errors;
      pending_bytes_o <= owed_bytes.size();
    end
  end

endmodule

// ===== dv/modbus_rtu_request_framer_tb.sv =====
// Top of the Modbus RTU request framer testbench: clock, reset, stimulus and verdict.
module modbus_rtu_request_framer_tb;
  import mrtu_pkg::*;

  // Spare kind code the framer ignores
  localparam logic [1:0] KindSpare = 2'd3;
  localparam int RandomItems = 175;
  localparam int LongHoldCycles = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [1:0]  kind_i;
  logic [7:0]  slave_address_i;
  logic [15:0] register_address_i;
  logic [7:0]  register_count_i;
  logic [15:0] data_word_i;
  logic        empty;
  logic        pop;
  logic [7:0]  frame_byte_o;
  logic        frame_last_o;
  int          error_count;
  int          pending_bytes;

  int          requests_sent;
  int          offers;
  bit          sender_eager;

  modbus_rtu_request_framer DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .kind_i             (kind_i),
    .slave_address_i    (slave_address_i),
    .register_address_i (register_address_i),
    .register_count_i   (register_count_i),
    .data_word_i        (data_word_i),
    .empty              (empty),
    .pop                (pop),
    .frame_byte_o       (frame_byte_o),
    .frame_last_o       (frame_last_o)
  );

  modbus_rtu_request_framer_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .kind_i             (kind_i),
    .slave_address_i    (slave_address_i),
    .register_address_i (register_address_i),
    .register_count_i   (register_count_i),
    .data_word_i        (data_word_i),
    .empty              (empty),
    .pop                (pop),
    .frame_byte_o       (frame_byte_o),
    .frame_last_o       (frame_last_o),
    .error_count_o      (error_count),
    .pending_bytes_o    (pending_bytes)
  );

  // Generate the clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Offer one item and hold it until it transfers; call at a falling edge
  task automatic offer_item(input logic [1:0] kind, input logic [7:0] slave,
                            input logic [15:0] addr, input logic [7:0] count,
                            input logic [15:0] word);
    int unsigned gap;
    if (offers % 16 == 0) begin
      sender_eager = ($urandom_range(0, 3) == 0);
    end
    offers++;
    gap = sender_eager ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i             = kind;
    slave_address_i    = slave;
    register_address_i = addr;
    register_count_i   = count;
    data_word_i        = word;
    push               = 1'b1;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  // Random write frame: start, its words, some abandoned and some with noise
  task automatic offer_write();
    logic [7:0] count;
    int         words;
    count = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, 6));
    words = (count > 8) ? $urandom_range(0, 8) : count;
    if (count != 0 && count <= 8 && $urandom_range(0, 7) == 0) begin
      words = $urandom_range(0, count - 1);
    end
    offer_item(KindStart, 8'($urandom), 16'($urandom), count, 16'($urandom));
    requests_sent++;
    for (int w = 0; w < words; w++) begin
      if ($urandom_range(0, 15) == 0) begin
        offer_item(KindSpare, 8'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
      end
      offer_item(KindData, 8'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
      requests_sent++;
    end
  endtask

  // Drain results with random stalls and two long hold-offs
  initial begin
    int unsigned taken;
    int unsigned stall;
    bit          receiver_eager;
    taken          = 0;
    receiver_eager = 1'b0;
    pop            = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken % 16 == 0) begin
        receiver_eager = ($urandom_range(0, 3) == 0);
      end
      if (taken == 40 || taken == 700) begin
        pop = 1'b0;
        repeat (LongHoldCycles) @(negedge clk_i);
      end
      stall = receiver_eager ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        pop = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pop = 1'b1;
      do @(posedge clk_i); while (empty);
      taken++;
      @(negedge clk_i);
    end
  end

  // Bound the run
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Reset, stimulus and verdict
  initial begin
    int unsigned pick;
    push               = 1'b0;
    kind_i             = KindRead;
    slave_address_i    = 8'h00;
    register_address_i = 16'h0000;
    register_count_i   = 8'h00;
    data_word_i        = 16'h0000;
    requests_sent      = 0;
    offers             = 0;
    sender_eager       = 1'b0;
    rst_ni             = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Read frames at the field extremes
    offer_item(KindRead, 8'h00, 16'h0000, 8'h00, 16'hFFFF);
    offer_item(KindRead, 8'hFF, 16'hFFFF, 8'hFF, 16'h0000);
    // Zero count write: header then CRC straight away
    offer_item(KindStart, 8'hA5, 16'h1234, 8'h00, 16'h0000);
    // Stray word and spare kind: both dropped
    offer_item(KindData, 8'h5A, 16'h4321, 8'h07, 16'hFFFF);
    offer_item(KindSpare, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    // Single register write
    offer_item(KindStart, 8'h01, 16'h0001, 8'h01, 16'h0000);
    offer_item(KindData, 8'h00, 16'h0000, 8'h00, 16'hFFFF);
    // Multiple register write
    offer_item(KindStart, 8'hF7, 16'hFF00, 8'h02, 16'h0000);
    offer_item(KindData, 8'h00, 16'h0000, 8'h00, 16'h0000);
    offer_item(KindData, 8'h00, 16'h0000, 8'h00, 16'hABCD);
    // Write cut short by a read, then a word with no write open
    offer_item(KindStart, 8'h11, 16'h00FF, 8'h03, 16'h0000);
    offer_item(KindData, 8'h00, 16'h0000, 8'h00, 16'h8001);
    offer_item(KindRead, 8'h22, 16'h5555, 8'h10, 16'h0000);
    offer_item(KindData, 8'h00, 16'h0000, 8'h00, 16'h1357);
    // Write cut short by a new start, spare kind inside the frame
    offer_item(KindStart, 8'h33, 16'hAAAA, 8'h05, 16'h0000);
    offer_item(KindData, 8'h00, 16'h0000, 8'h00, 16'h7FFE);
    offer_item(KindStart, 8'h44, 16'h0F0F, 8'h02, 16'h0000);
    offer_item(KindSpare, 8'h00, 16'h0000, 8'h00, 16'h0000);
    offer_item(KindData, 8'h00, 16'h0000, 8'h00, 16'h2468);
    offer_item(KindData, 8'h00, 16'h0000, 8'h00, 16'hF0F0);
    // Byte count truncation and the largest count, both abandoned
    offer_item(KindStart, 8'h55, 16'hF0F0, 8'h80, 16'h0000);
    offer_item(KindStart, 8'h66, 16'h8000, 8'hFF, 16'h0000);
    offer_item(KindRead, 8'h77, 16'h0100, 8'h01, 16'h0000);

    // Random requests, mostly well-formed write frames
    while (requests_sent < RandomItems) begin
      pick = $urandom_range(0, 19);
      if (pick < 5) begin
        offer_item(KindRead, 8'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
        requests_sent++;
      end else if (pick < 6) begin
        offer_item(KindData, 8'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
      end else if (pick < 7) begin
        offer_item(KindSpare, 8'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
      end else begin
        offer_write();
      end
    end
    // Close any write left open so every frame ends with a CRC
    offer_item(KindRead, 8'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
    push = 1'b0;

    // Drain, then watch for stray results
    while (pending_bytes != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
